// ===== design/art_pkg.sv =====
// shared types and constants for the retransmit table
// used by art_ctrl, art_dp and arq_retransmit_table
package art_pkg;

	localparam int DEPTH_DEF      = 32;
	localparam int MAX_REPORT_DEF = 64;
	localparam int SEQ_W          = 32;
	localparam int TIME_W         = 48;
	localparam int HDL_W          = 16;
	localparam int TMO_W          = 16;
	localparam int MODE_W         = 3;
	localparam int CAP_W          = 6;
	localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;

	localparam logic [MODE_W-1:0] MODE_TICK = 3'd0;
	localparam logic [MODE_W-1:0] MODE_ADD  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_RM   = 3'd2;
	localparam logic [MODE_W-1:0] MODE_GET  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_ALL  = 3'd4;
	localparam logic [MODE_W-1:0] MODE_MISS = 3'd5;

	typedef struct packed {
		logic              valid;
		logic [SEQ_W-1:0]  seq;
		logic [TIME_W-1:0] expiry;
		logic [HDL_W-1:0]  handle;
	} entry_t;

	typedef enum logic [1:0] {EM_NONE, EM_RES, EM_EMPTY, EM_ITEM} em_t;
	typedef enum logic [1:0] {SRC_THR, SRC_NXT, SRC_G} src_t;

	typedef struct packed {
		logic load;
		logic tick;
		logic scan_go;
		logic clr;
		logic wr_add;
		logic wr_rm;
		logic list_init;
		logic miss;
		logic adv_nxt;
		logic inc_g;
		em_t  em;
		logic ok;
		logic hsel;
		src_t src;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic scan_last;
		logic add_ok;
		logic match;
		logic e_zero;
		logic k_last;
		logic g_lt_nxt;
	} stat_t;

endpackage

// ===== design/art_dp.sv =====
// datapath of the retransmit table: entry memory, scan statistics, list counters
// and result word registers; depends on art_pkg
module art_dp import art_pkg::*; #(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int MAX_REPORT = MAX_REPORT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	input  logic [SEQ_W-1:0]  seq_num,
	input  logic [HDL_W-1:0]  payload_handle,
	input  logic [TMO_W-1:0]  timeout_ticks,
	input  logic [CAP_W-1:0]  capacity_limit,
	output stat_t             st,
	output logic              result_valid,
	output logic              success,
	output logic [SEQ_W-1:0]  seq_num_out,
	output logic [HDL_W-1:0]  handle_out,
	output logic              item_valid,
	output logic              truncated,
	output logic              last
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int KW = $clog2(MAX_REPORT + 1);
	localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

	entry_t mem [DEPTH];
	entry_t rd_s1;
	logic [AW-1:0] addr_q, addr_s1;
	logic scanning_q, v_s1;

	logic [SEQ_W-1:0]  seq_q;
	logic [HDL_W-1:0]  hdl_q;
	logic [TMO_W-1:0]  tmo_q;
	logic [TIME_W-1:0] now_q;

	logic [CW-1:0]    cnt_q;
	logic             free_f_q, match_f_q, nxt_f_q;
	logic [AW-1:0]    free_q, match_q;
	logic [HDL_W-1:0] mhdl_q;
	logic [SEQ_W-1:0] min_q, max_q, nxt_q, thr_q, g_q;
	logic [KW-1:0]    k_q, e_q;
	logic             cut_q;

	logic live, dead;
	logic we;
	logic [AW-1:0] wa;
	entry_t wd;
	logic [TIME_W:0] exp_sum;
	logic [SEQ_W:0] span, total;
	logic add_ok;
	logic [SEQ_W-1:0] item_val;

	assign live = rd_s1.valid && !(rd_s1.expiry < now_q);
	assign dead = rd_s1.valid && !live;
	assign exp_sum = {1'b0, now_q} + (TIME_W+1)'(tmo_q);
	assign add_ok = (32'(cnt_q) < 32'(capacity_limit)) && free_f_q;

	assign span = {1'b0, max_q} - {1'b0, min_q} + (SEQ_W+1)'(1);
	always_comb begin
		if (!cmd.miss) begin
			total = (SEQ_W+1)'(cnt_q);
		end else if (cnt_q >= CW'(2)) begin
			total = span - (SEQ_W+1)'(cnt_q);
		end else begin
			total = '0;
		end
	end

	always_comb begin
		case (cmd.src)
			SRC_THR: item_val = thr_q;
			SRC_NXT: item_val = nxt_q;
			SRC_G:   item_val = g_q;
			default: item_val = thr_q;
		endcase
	end

	always_comb begin
		we = 1'b0;
		wa = addr_s1;
		wd = '0;
		if (cmd.clr) begin
			we = 1'b1;
			wa = addr_q;
		end else if (v_s1 && dead) begin
			we = 1'b1;
		end else if (cmd.wr_add && add_ok && !match_f_q) begin
			we = 1'b1;
			wa = free_q;
			wd.valid = 1'b1;
			wd.seq = seq_q;
			wd.expiry = exp_sum[TIME_W] ? '1 : exp_sum[TIME_W-1:0];
			wd.handle = hdl_q;
		end else if (cmd.wr_rm && match_f_q) begin
			we = 1'b1;
			wa = match_q;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd_s1 <= mem[addr_q];
	end

	assign st.clr_last  = (addr_q == LAST_ADDR);
	assign st.scan_last = v_s1 && (addr_s1 == LAST_ADDR);
	assign st.add_ok    = add_ok;
	assign st.match     = match_f_q;
	assign st.e_zero    = (e_q == '0);
	assign st.k_last    = (({1'b0, k_q} + (KW+1)'(1)) == {1'b0, e_q});
	assign st.g_lt_nxt  = (g_q < nxt_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
			addr_s1 <= '0;
			scanning_q <= 1'b0;
			v_s1 <= 1'b0;
			seq_q <= '0;
			hdl_q <= '0;
			tmo_q <= '0;
			now_q <= '0;
			cnt_q <= '0;
			free_f_q <= 1'b0;
			match_f_q <= 1'b0;
			nxt_f_q <= 1'b0;
			free_q <= '0;
			match_q <= '0;
			mhdl_q <= '0;
			min_q <= '0;
			max_q <= '0;
			nxt_q <= '0;
			thr_q <= '0;
			g_q <= '0;
			k_q <= '0;
			e_q <= '0;
			cut_q <= 1'b0;
			result_valid <= 1'b0;
			success <= 1'b0;
			seq_num_out <= '0;
			handle_out <= '0;
			item_valid <= 1'b0;
			truncated <= 1'b0;
			last <= 1'b0;
		end else begin
			v_s1 <= scanning_q;
			addr_s1 <= addr_q;
			if (cmd.load) begin
				seq_q <= seq_num;
				hdl_q <= payload_handle;
				tmo_q <= timeout_ticks;
			end
			if (cmd.tick && (now_q != '1)) begin
				now_q <= now_q + TIME_W'(1);
			end
			if (cmd.scan_go) begin
				addr_q <= '0;
				scanning_q <= 1'b1;
				cnt_q <= '0;
				free_f_q <= 1'b0;
				match_f_q <= 1'b0;
				nxt_f_q <= 1'b0;
			end else if (cmd.clr || scanning_q) begin
				addr_q <= (addr_q == LAST_ADDR) ? '0 : addr_q + AW'(1);
				if (addr_q == LAST_ADDR) begin
					scanning_q <= 1'b0;
				end
			end
			if (v_s1) begin
				if (live) begin
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == '0 || rd_s1.seq < min_q) begin
						min_q <= rd_s1.seq;
					end
					if (cnt_q == '0 || rd_s1.seq > max_q) begin
						max_q <= rd_s1.seq;
					end
					if (!match_f_q && rd_s1.seq == seq_q) begin
						match_f_q <= 1'b1;
						match_q <= addr_s1;
						mhdl_q <= rd_s1.handle;
					end
					if (rd_s1.seq > thr_q && (!nxt_f_q || rd_s1.seq < nxt_q)) begin
						nxt_f_q <= 1'b1;
						nxt_q <= rd_s1.seq;
					end
				end else if (!free_f_q) begin
					free_f_q <= 1'b1;
					free_q <= addr_s1;
				end
			end
			if (cmd.list_init) begin
				cut_q <= total > (SEQ_W+1)'(MAX_REPORT);
				e_q <= (total > (SEQ_W+1)'(MAX_REPORT)) ? KW'(MAX_REPORT) : total[KW-1:0];
				k_q <= '0;
				thr_q <= min_q;
				g_q <= min_q + SEQ_W'(1);
			end
			if (cmd.adv_nxt) begin
				thr_q <= nxt_q;
				g_q <= nxt_q + SEQ_W'(1);
			end
			if (cmd.inc_g) begin
				g_q <= g_q + SEQ_W'(1);
			end
			result_valid <= (cmd.em != EM_NONE);
			case (cmd.em)
				EM_RES: begin
					success <= cmd.ok;
					seq_num_out <= '0;
					handle_out <= cmd.hsel && match_f_q ? mhdl_q : '0;
					item_valid <= 1'b0;
					truncated <= 1'b0;
					last <= 1'b1;
				end
				EM_EMPTY: begin
					success <= 1'b1;
					seq_num_out <= '0;
					handle_out <= '0;
					item_valid <= 1'b0;
					truncated <= cut_q;
					last <= 1'b1;
				end
				EM_ITEM: begin
					success <= 1'b1;
					seq_num_out <= item_val;
					handle_out <= '0;
					item_valid <= 1'b1;
					truncated <= cut_q;
					last <= st.k_last;
					k_q <= k_q + KW'(1);
				end
				default: begin
				end
			endcase
		end
	end

	a_k_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(k_q <= e_q)) else $error("list count passed its bound");
	a_item_ok: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && item_valid |-> success) else $error("listed word without success");
	a_scan_end: assert property (@(posedge clk) disable iff (!arst_n)
		st.scan_last |-> !scanning_q) else $error("scan ended while still reading");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(cnt_q) <= 32'(DEPTH))) else $error("entry count above depth");

endmodule

// ===== design/art_ctrl.sv =====
// controller state machine of the retransmit table
// drives art_dp through cmd_t and reads stat_t; depends on art_pkg
module art_ctrl import art_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [MODE_W-1:0] mode,
	input  stat_t             st,
	output cmd_t              cmd,
	output logic              busy
);

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_SCAN, S_ACT, S_LCHK, S_LSCAN, S_LALL, S_GAP
	} state_t;

	state_t state_q, state_d;
	logic [MODE_W-1:0] mode_q;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		cmd = '0;
		cmd.em = EM_NONE;
		cmd.src = SRC_THR;
		cmd.miss = (mode_q == MODE_MISS);
		state_d = state_q;
		case (state_q)
			S_CLR: begin
				cmd.clr = 1'b1;
				if (st.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					case (mode)
						MODE_TICK: begin
							cmd.tick = 1'b1;
							cmd.em = EM_RES;
							cmd.ok = 1'b1;
						end
						MODE_ADD, MODE_RM, MODE_GET, MODE_ALL, MODE_MISS: begin
							cmd.load = 1'b1;
							cmd.scan_go = 1'b1;
							state_d = S_SCAN;
						end
						default: begin
							cmd.em = EM_RES;
						end
					endcase
				end
			end
			S_SCAN: begin
				if (st.scan_last) begin
					state_d = S_ACT;
				end
			end
			S_ACT: begin
				state_d = S_IDLE;
				case (mode_q)
					MODE_ADD: begin
						cmd.wr_add = 1'b1;
						cmd.em = EM_RES;
						cmd.ok = st.add_ok;
					end
					MODE_RM: begin
						cmd.wr_rm = 1'b1;
						cmd.em = EM_RES;
						cmd.ok = st.match;
					end
					MODE_GET: begin
						cmd.em = EM_RES;
						cmd.ok = st.match;
						cmd.hsel = 1'b1;
					end
					default: begin
						cmd.list_init = 1'b1;
						state_d = S_LCHK;
					end
				endcase
			end
			S_LCHK: begin
				if (st.e_zero) begin
					cmd.em = EM_EMPTY;
					state_d = S_IDLE;
				end else if (mode_q == MODE_ALL) begin
					cmd.em = EM_ITEM;
					cmd.src = SRC_THR;
					if (st.k_last) begin
						state_d = S_IDLE;
					end else begin
						cmd.scan_go = 1'b1;
						state_d = S_LSCAN;
					end
				end else begin
					cmd.scan_go = 1'b1;
					state_d = S_LSCAN;
				end
			end
			S_LSCAN: begin
				if (st.scan_last) begin
					state_d = (mode_q == MODE_ALL) ? S_LALL : S_GAP;
				end
			end
			S_LALL: begin
				cmd.em = EM_ITEM;
				cmd.src = SRC_NXT;
				cmd.adv_nxt = 1'b1;
				if (st.k_last) begin
					state_d = S_IDLE;
				end else begin
					cmd.scan_go = 1'b1;
					state_d = S_LSCAN;
				end
			end
			S_GAP: begin
				if (st.g_lt_nxt) begin
					cmd.em = EM_ITEM;
					cmd.src = SRC_G;
					cmd.inc_g = 1'b1;
					if (st.k_last) begin
						state_d = S_IDLE;
					end
				end else begin
					cmd.adv_nxt = 1'b1;
					cmd.scan_go = 1'b1;
					state_d = S_LSCAN;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			mode_q <= MODE_TICK;
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE && start) begin
				mode_q <= mode;
			end
		end
	end

endmodule

// ===== design/arq_retransmit_table.sv =====
// Retransmit table, top level: config register, controller and datapath.
// After reset a clearing pass over the entry memory runs with busy high. A tick
// or an unknown mode is answered from idle and busy stays low. Add, remove
// and get make one pass over the entry memory through its single registered
// read port. List all runs one pass per listed number; list missing one pass
// per stored number it steps past, reporting the gap numbers between passes.
// Results come as single-cycle words on result_valid and cannot be held off.
// depends on art_pkg, art_ctrl, art_dp
module arq_retransmit_table import art_pkg::*; #(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int MAX_REPORT = MAX_REPORT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  logic              start,
	output logic              busy,
	input  logic [MODE_W-1:0] mode,
	input  logic [SEQ_W-1:0]  seq_num,
	input  logic [HDL_W-1:0]  payload_handle,
	input  logic [TMO_W-1:0]  timeout_ticks,
	output logic              result_valid,
	output logic              success,
	output logic [SEQ_W-1:0]  seq_num_out,
	output logic [HDL_W-1:0]  handle_out,
	output logic              item_valid,
	output logic              truncated,
	output logic              last
);

	logic [CAP_W-1:0] cap_q;
	cmd_t cmd;
	stat_t st;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? 32'(cap_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (psel && penable && pwrite && pready && !paddr[2]) begin
			cap_q <= pwdata[CAP_W-1:0];
		end
	end

	art_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mode   (mode),
		.st     (st),
		.cmd    (cmd),
		.busy   (busy)
	);

	art_dp #(
		.DEPTH      (DEPTH),
		.MAX_REPORT (MAX_REPORT)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.seq_num        (seq_num),
		.payload_handle (payload_handle),
		.timeout_ticks  (timeout_ticks),
		.capacity_limit (cap_q),
		.st             (st),
		.result_valid   (result_valid),
		.success        (success),
		.seq_num_out    (seq_num_out),
		.handle_out     (handle_out),
		.item_valid     (item_valid),
		.truncated      (truncated),
		.last           (last)
	);

endmodule

// ===== bench/arq_retransmit_table_test.sv =====
// testbench for arq_retransmit_table: directed table, then random command words
// checked word by word against a behavioral table model; capacity set over apb
// depends on art_pkg and the arq_retransmit_table rtl
module arq_retransmit_table_test import art_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          N_SLOT    = 32;
	localparam int          N_REPORT  = 64;
	localparam logic [47:0] TICK_MAX  = 48'hFFFF_FFFF_FFFF;
	localparam logic [2:0]  MODE_BAD6 = 3'd6;
	localparam logic [2:0]  MODE_BAD7 = 3'd7;
	localparam logic [2:0]  ADDR_CAPACITY = 3'd0;
	localparam int          CYCLE_LIMIT = 3000000;
	localparam int          RANDOM_ITEMS = 500;

	typedef struct {
		logic        success;
		logic [31:0] seq_num_out;
		logic [15:0] handle_out;
		logic        item_valid;
		logic        truncated;
		logic        last;
	} word_t;

	typedef struct {
		logic [2:0]  mode;
		logic [31:0] seq;
		logic [15:0] hdl;
		logic [15:0] tmo;
		bit          typed;
		logic        ok;
		logic [15:0] hdl_e;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic start = 1'b0;
	logic busy;
	logic [MODE_W-1:0] mode = MODE_TICK;
	logic [SEQ_W-1:0] seq_num = '0;
	logic [HDL_W-1:0] payload_handle = '0;
	logic [TMO_W-1:0] timeout_ticks = '0;
	logic result_valid, success, item_valid, truncated, last;
	logic [SEQ_W-1:0] seq_num_out;
	logic [HDL_W-1:0] handle_out;

	// table model state
	logic [47:0] now_ticks;
	logic [5:0]  capacity;
	bit          slot_used[N_SLOT];
	logic [31:0] slot_seq[N_SLOT];
	logic [47:0] slot_expiry[N_SLOT];
	logic [15:0] slot_handle[N_SLOT];

	word_t pending_words[$];
	bit    typed_now = 1'b0;
	word_t typed_word;
	int    mismatches = 0;
	int    cycles = 0;
	int    idle_pct = 0;
	logic [31:0] seq_base;

	arq_retransmit_table uut (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic word_t mk(logic ok, logic [31:0] s, logic [15:0] h, logic iv,
			logic ls);
		word_t w;
		w.success = ok; w.seq_num_out = s; w.handle_out = h;
		w.item_valid = iv; w.truncated = 1'b0; w.last = ls;
		return w;
	endfunction

	task automatic table_step(input logic [2:0] m, input logic [31:0] s,
			input logic [15:0] h, input logic [15:0] t, input bit keep);
		word_t outs[$];
		logic [31:0] srt[N_SLOT];
		logic [31:0] tmp;
		logic [48:0] sum;
		longint unsigned v;
		int i, j, n, slot, cnt, at;
		bit cut;
		cut = 1'b0; n = 0; slot = -1; cnt = 0; at = -1;
		if (m == MODE_TICK) begin
			if (now_ticks < TICK_MAX) now_ticks++;
			outs.insert(outs.size(), mk(1'b1, 32'd0, 16'd0, 1'b0, 1'b1));
		end else if (m > MODE_MISS) begin
			outs.insert(outs.size(), mk(1'b0, 32'd0, 16'd0, 1'b0, 1'b1));
		end else begin
			for (i = 0; i < N_SLOT; i++)
				if (slot_used[i] && slot_expiry[i] < now_ticks) slot_used[i] = 1'b0;
			for (i = 0; i < N_SLOT; i++)
				if (slot_used[i] && slot_seq[i] == s && at < 0) at = i;
			if (m == MODE_ADD) begin
				for (i = 0; i < N_SLOT; i++)
					if (slot_used[i]) cnt++;
					else if (slot < 0) slot = i;
				if (cnt >= capacity || slot < 0) begin
					outs.insert(outs.size(), mk(1'b0, 32'd0, 16'd0, 1'b0, 1'b1));
				end else begin
					if (at < 0) begin
						sum = now_ticks + t;
						slot_used[slot] = 1'b1;
						slot_seq[slot] = s;
						slot_expiry[slot] = sum > TICK_MAX ? TICK_MAX : sum[47:0];
						slot_handle[slot] = h;
					end
					outs.insert(outs.size(), mk(1'b1, 32'd0, 16'd0, 1'b0, 1'b1));
				end
			end else if (m == MODE_RM || m == MODE_GET) begin
				if (at < 0) outs.insert(outs.size(), mk(1'b0, 32'd0, 16'd0, 1'b0, 1'b1));
				else if (m == MODE_RM) begin
					slot_used[at] = 1'b0;
					outs.insert(outs.size(), mk(1'b1, 32'd0, 16'd0, 1'b0, 1'b1));
				end else
					outs.insert(outs.size(), mk(1'b1, 32'd0, slot_handle[at], 1'b0, 1'b1));
			end else begin
				for (i = 0; i < N_SLOT; i++) begin
					if (slot_used[i]) begin
						j = n;
						while (j > 0 && srt[j-1] > slot_seq[i]) begin
							srt[j] = srt[j-1];
							j--;
						end
						srt[j] = slot_seq[i];
						n++;
					end
				end
				if (m == MODE_ALL) begin
					for (i = 0; i < n; i++) begin
						if (outs.size() >= N_REPORT) begin
							cut = 1'b1;
							break;
						end
						outs.insert(outs.size(), mk(1'b1, srt[i], 16'd0, 1'b1, 1'b0));
					end
				end else begin
					for (i = 1; i < n && !cut; i++)
						for (v = longint'(srt[i-1]) + 1; v < srt[i]; v++) begin
							if (outs.size() >= N_REPORT) begin
								cut = 1'b1;
								break;
							end
							tmp = v[31:0];
							outs.insert(outs.size(), mk(1'b1, tmp, 16'd0, 1'b1, 1'b0));
						end
				end
				if (outs.size() == 0)
					outs.insert(outs.size(), mk(1'b1, 32'd0, 16'd0, 1'b0, 1'b1));
				foreach (outs[i]) outs[i].truncated = cut;
				outs[outs.size()-1].last = 1'b1;
			end
		end
		if (keep) foreach (outs[i]) pending_words.insert(pending_words.size(), outs[i]);
	endtask

	always @(posedge clk) begin
		word_t w;
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end else begin
			if (arst_n && start && !busy) begin
				table_step(mode, seq_num, payload_handle, timeout_ticks, !typed_now);
				if (typed_now) pending_words.insert(pending_words.size(), typed_word);
			end
			if (result_valid) begin
				if (pending_words.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected word seq_num_out=%h", seq_num_out);
				end else begin
					w = pending_words.pop_front();
					if (success !== w.success || seq_num_out !== w.seq_num_out ||
							handle_out !== w.handle_out || item_valid !== w.item_valid ||
							truncated !== w.truncated || last !== w.last) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch exp %b %h %h %b %b %b got %b %h %h %b %b %b",
								w.success, w.seq_num_out, w.handle_out, w.item_valid,
								w.truncated, w.last, success, seq_num_out, handle_out,
								item_valid, truncated, last);
					end
				end
			end
		end
	end

	task automatic send(input logic [2:0] m, input logic [31:0] s, input logic [15:0] h,
			input logic [15:0] t, input bit typed, input logic ok, input logic [15:0] he);
		@(negedge clk);
		start <= 1'b1;
		mode <= m;
		seq_num <= s;
		payload_handle <= h;
		timeout_ticks <= t;
		typed_now <= typed;
		typed_word <= mk(ok, 32'd0, he, 1'b0, 1'b1);
		do @(posedge clk); while (busy);
		if ($urandom_range(0, 99) < idle_pct) begin
			@(negedge clk);
			start <= 1'b0;
			repeat ($urandom_range(0, 5)) @(negedge clk);
		end
	endtask

	task automatic drain_and_set_capacity(input logic [5:0] cap);
		@(negedge clk);
		start <= 1'b0;
		while (pending_words.size() != 0) @(posedge clk);
		repeat (N_SLOT + 10) @(posedge clk);
		while (busy) @(posedge clk);
		@(negedge clk);
		psel <= 1'b1; pwrite <= 1'b1; paddr <= ADDR_CAPACITY; pwdata <= {26'd0, cap};
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		capacity = cap;
	endtask

	task automatic random_item();
		int r;
		logic [2:0] m;
		logic [31:0] s;
		logic [15:0] t;
		r = $urandom_range(0, 99);
		m = r < 15 ? MODE_TICK : r < 50 ? MODE_ADD : r < 62 ? MODE_RM :
			r < 77 ? MODE_GET : r < 87 ? MODE_ALL : r < 97 ? MODE_MISS :
			(r[0] ? MODE_BAD6 : MODE_BAD7);
		s = $urandom_range(0, 9) == 0 ? $urandom : seq_base + $urandom_range(0, 40);
		t = $urandom_range(0, 9) < 7 ? 16'($urandom_range(0, 15)) : 16'($urandom);
		send(m, s, 16'($urandom), t, 1'b0, 1'b0, 16'd0);
	endtask

	row_t rows[] = '{
		'{MODE_ALL,  32'd0,        16'h0,    16'h0,    1'b1, 1'b1, 16'h0},
		'{MODE_MISS, 32'd0,        16'h0,    16'h0,    1'b1, 1'b1, 16'h0},
		'{MODE_GET,  32'd5,        16'h0,    16'h0,    1'b1, 1'b0, 16'h0},
		'{MODE_RM,   32'd5,        16'h0,    16'h0,    1'b1, 1'b0, 16'h0},
		'{MODE_TICK, 32'd0,        16'h0,    16'h0,    1'b1, 1'b1, 16'h0},
		'{MODE_BAD6, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 16'h0},
		'{MODE_BAD7, 32'd0,        16'h0,    16'h0,    1'b1, 1'b0, 16'h0},
		'{MODE_ADD,  32'd0,        16'h0,    16'h0,    1'b1, 1'b1, 16'h0},
		'{MODE_ADD,  32'hFFFFFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 16'h0},
		'{MODE_ADD,  32'd0,        16'h1234, 16'h0,    1'b1, 1'b1, 16'h0},
		'{MODE_GET,  32'd0,        16'h0,    16'h0,    1'b1, 1'b1, 16'h0},
		'{MODE_GET,  32'hFFFFFFFF, 16'h0,    16'h0,    1'b1, 1'b1, 16'hFFFF},
		'{MODE_ALL,  32'd0,        16'h0,    16'h0,    1'b0, 1'b0, 16'h0},
		'{MODE_MISS, 32'd0,        16'h0,    16'h0,    1'b0, 1'b0, 16'h0},
		'{MODE_ADD,  32'd10,       16'hA5A5, 16'd1,    1'b0, 1'b0, 16'h0},
		'{MODE_TICK, 32'd0,        16'h0,    16'h0,    1'b0, 1'b0, 16'h0},
		'{MODE_TICK, 32'd0,        16'h0,    16'h0,    1'b0, 1'b0, 16'h0},
		'{MODE_GET,  32'd10,       16'h0,    16'h0,    1'b0, 1'b0, 16'h0},
		'{MODE_RM,   32'hFFFFFFFF, 16'h0,    16'h0,    1'b0, 1'b0, 16'h0},
		'{MODE_ADD,  32'd100,      16'h5A5A, 16'd5,    1'b0, 1'b0, 16'h0},
		'{MODE_ADD,  32'd103,      16'h0F0F, 16'd5,    1'b0, 1'b0, 16'h0},
		'{MODE_MISS, 32'd0,        16'h0,    16'h0,    1'b0, 1'b0, 16'h0},
		'{MODE_RM,   32'd0,        16'h0,    16'h0,    1'b0, 1'b0, 16'h0},
		'{MODE_MISS, 32'd0,        16'h0,    16'h0,    1'b0, 1'b0, 16'h0},
		'{MODE_ALL,  32'd0,        16'h0,    16'h0,    1'b0, 1'b0, 16'h0}
	};

	logic [5:0] cap_plan[5] = '{6'd1, 6'd63, 6'd0, 6'd3, 6'd32};
	int         pct_plan[5] = '{13, 13, 70, 70, 0};

	initial begin
		now_ticks = '0;
		capacity = CAP_RESET;
		foreach (slot_used[i]) slot_used[i] = 1'b0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		foreach (rows[i])
			send(rows[i].mode, rows[i].seq, rows[i].hdl, rows[i].tmo, rows[i].typed,
				rows[i].ok, rows[i].hdl_e);
		for (int p = 0; p < 5; p++) begin
			drain_and_set_capacity(cap_plan[p]);
			idle_pct = pct_plan[p];
			seq_base = $urandom;
			for (int i = 0; i < RANDOM_ITEMS / 5; i++) random_item();
		end
		@(negedge clk);
		start <= 1'b0;
		while (pending_words.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (mismatches == 0 && pending_words.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end
endmodule
